// ===== hdl/bbp_pkg.sv =====
// Shared types and constants for the ball bounce physics step core.
// Holds operation codes, register indexes, datapath command codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package bbp_pkg;

	localparam int SCREEN_W = 800;
	localparam int SCREEN_H = 600;

	localparam logic [31:0] POS_X_RST = 32'(SCREEN_W / 2) << 16;
	localparam logic [31:0] POS_Y_RST = 32'(SCREEN_H / 2) << 16;

	localparam logic [31:0] GRAVITY_RST   = 32'd642908;
	localparam logic [30:0] MIN_SPEED_RST = 31'd9830400;
	localparam logic [30:0] MAX_SPEED_RST = 31'd32768000;

	// operation codes
	localparam logic [1:0] OP_GRAVITY = 2'd0;
	localparam logic [1:0] OP_MOVE    = 2'd1;
	localparam logic [1:0] OP_BOUNCE  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_GRAVITY   = 2'd0;
	localparam logic [1:0] REG_MIN_SPEED = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED = 2'd2;

	// multiplier operand selects
	localparam logic [4:0] MUL_NONE = 5'd0;
	localparam logic [4:0] MUL_VXVX = 5'd1;
	localparam logic [4:0] MUL_VYVY = 5'd2;
	localparam logic [4:0] MUL_VXNX = 5'd3;
	localparam logic [4:0] MUL_VYNY = 5'd4;
	localparam logic [4:0] MUL_VXDT = 5'd5;
	localparam logic [4:0] MUL_VYDT = 5'd6;
	localparam logic [4:0] MUL_GDT  = 5'd7;
	localparam logic [4:0] MUL_MAG  = 5'd8;
	localparam logic [4:0] MUL_DNX  = 5'd9;
	localparam logic [4:0] MUL_DNY  = 5'd10;
	localparam logic [4:0] MUL_BXBX = 5'd11;
	localparam logic [4:0] MUL_BYBY = 5'd12;
	localparam logic [4:0] MUL_SBX  = 5'd13;
	localparam logic [4:0] MUL_SBY  = 5'd14;
	localparam logic [4:0] MUL_PNX  = 5'd15;
	localparam logic [4:0] MUL_PNY  = 5'd16;

	// datapath actions
	localparam logic [4:0] ACT_NONE      = 5'd0;
	localparam logic [4:0] ACT_GRAV      = 5'd1;
	localparam logic [4:0] ACT_VY_ADD    = 5'd2;
	localparam logic [4:0] ACT_MOVE_X    = 5'd3;
	localparam logic [4:0] ACT_MOVE_Y    = 5'd4;
	localparam logic [4:0] ACT_ACC_LD    = 5'd5;
	localparam logic [4:0] ACT_ACC_ADD   = 5'd6;
	localparam logic [4:0] ACT_SQRT_LD   = 5'd7;
	localparam logic [4:0] ACT_SQRT_STEP = 5'd8;
	localparam logic [4:0] ACT_SPEED     = 5'd9;
	localparam logic [4:0] ACT_DOT_LD    = 5'd10;
	localparam logic [4:0] ACT_DOT_RND   = 5'd11;
	localparam logic [4:0] ACT_RX        = 5'd12;
	localparam logic [4:0] ACT_RY        = 5'd13;
	localparam logic [4:0] ACT_HALVE     = 5'd14;
	localparam logic [4:0] ACT_DEGEN     = 5'd15;
	localparam logic [4:0] ACT_DIV_LD    = 5'd16;
	localparam logic [4:0] ACT_DIV_STEP  = 5'd17;
	localparam logic [4:0] ACT_VX_SET    = 5'd18;
	localparam logic [4:0] ACT_VY_SET    = 5'd19;
	localparam logic [4:0] ACT_PUSH_X    = 5'd20;
	localparam logic [4:0] ACT_PUSH_Y    = 5'd21;
	localparam logic [4:0] ACT_OUT       = 5'd22;

	typedef struct packed {
		logic       capture;
		logic [4:0] mul_sel;
		logic [4:0] act;
	} bbp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       bounce_go;
		logic       sqrt_last;
		logic       div_last;
		logic       need_halve;
		logic       len_zero;
	} bbp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bbp_ctrl.sv =====
// Sequencing controller for the ball bounce physics step core.
// Depends on bbp_pkg for command/status structs and codes.
`default_nettype none

module bbp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  bbp_pkg::bbp_sts_t    sts,
	output bbp_pkg::bbp_cmd_t    cmd
);
	import bbp_pkg::*;

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] S_DISP    = 6'd1;
	localparam logic [5:0] S_G_MUL   = 6'd2;
	localparam logic [5:0] S_G_SCALE = 6'd3;
	localparam logic [5:0] S_G_ADD   = 6'd4;
	localparam logic [5:0] S_M_X     = 6'd5;
	localparam logic [5:0] S_M_Y     = 6'd6;
	localparam logic [5:0] S_M_END   = 6'd7;
	localparam logic [5:0] S_B_SQX   = 6'd8;
	localparam logic [5:0] S_B_SQY   = 6'd9;
	localparam logic [5:0] S_B_SUM   = 6'd10;
	localparam logic [5:0] S_B_SQLD  = 6'd11;
	localparam logic [5:0] S_B_SQ    = 6'd12;
	localparam logic [5:0] S_B_MAG   = 6'd13;
	localparam logic [5:0] S_B_SPD   = 6'd14;
	localparam logic [5:0] S_B_DOT   = 6'd15;
	localparam logic [5:0] S_B_D     = 6'd16;
	localparam logic [5:0] S_B_DNX   = 6'd17;
	localparam logic [5:0] S_B_RX    = 6'd18;
	localparam logic [5:0] S_B_RY    = 6'd19;
	localparam logic [5:0] S_B_HALVE = 6'd20;
	localparam logic [5:0] S_B_BSQX  = 6'd21;
	localparam logic [5:0] S_B_BSQY  = 6'd22;
	localparam logic [5:0] S_B_BSUM  = 6'd23;
	localparam logic [5:0] S_B_LSQLD = 6'd24;
	localparam logic [5:0] S_B_LSQ   = 6'd25;
	localparam logic [5:0] S_B_LCHK  = 6'd26;
	localparam logic [5:0] S_B_DXLD  = 6'd27;
	localparam logic [5:0] S_B_DX    = 6'd28;
	localparam logic [5:0] S_B_VX    = 6'd29;
	localparam logic [5:0] S_B_DYLD  = 6'd30;
	localparam logic [5:0] S_B_DY    = 6'd31;
	localparam logic [5:0] S_B_VY    = 6'd32;
	localparam logic [5:0] S_B_PNX   = 6'd33;
	localparam logic [5:0] S_B_PUSHX = 6'd34;
	localparam logic [5:0] S_B_PUSHY = 6'd35;
	localparam logic [5:0] S_DONE    = 6'd36;

	logic [5:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_NONE;
		cmd.act     = ACT_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_GRAVITY: state_d = S_G_MUL;
					OP_MOVE:    state_d = S_M_X;
					OP_BOUNCE:  state_d = sts.bounce_go ? S_B_SQX : S_DONE;
					default:    state_d = S_DONE;
				endcase
			end
			S_G_MUL: begin
				cmd.mul_sel = MUL_GDT;
				state_d     = S_G_SCALE;
			end
			S_G_SCALE: begin
				cmd.act = ACT_GRAV;
				state_d = S_G_ADD;
			end
			S_G_ADD: begin
				cmd.act = ACT_VY_ADD;
				state_d = S_DONE;
			end
			S_M_X: begin
				cmd.mul_sel = MUL_VXDT;
				state_d     = S_M_Y;
			end
			S_M_Y: begin
				cmd.mul_sel = MUL_VYDT;
				cmd.act     = ACT_MOVE_X;
				state_d     = S_M_END;
			end
			S_M_END: begin
				cmd.act = ACT_MOVE_Y;
				state_d = S_DONE;
			end
			S_B_SQX: begin
				cmd.mul_sel = MUL_VXVX;
				state_d     = S_B_SQY;
			end
			S_B_SQY: begin
				cmd.mul_sel = MUL_VYVY;
				cmd.act     = ACT_ACC_LD;
				state_d     = S_B_SUM;
			end
			S_B_SUM: begin
				cmd.act = ACT_ACC_ADD;
				state_d = S_B_SQLD;
			end
			S_B_SQLD: begin
				cmd.act = ACT_SQRT_LD;
				state_d = S_B_SQ;
			end
			S_B_SQ: begin
				cmd.act = ACT_SQRT_STEP;
				if (sts.sqrt_last)
					state_d = S_B_MAG;
			end
			S_B_MAG: begin
				cmd.mul_sel = MUL_MAG;
				state_d     = S_B_SPD;
			end
			S_B_SPD: begin
				cmd.act     = ACT_SPEED;
				cmd.mul_sel = MUL_VXNX;
				state_d     = S_B_DOT;
			end
			S_B_DOT: begin
				cmd.act     = ACT_DOT_LD;
				cmd.mul_sel = MUL_VYNY;
				state_d     = S_B_D;
			end
			S_B_D: begin
				cmd.act = ACT_DOT_RND;
				state_d = S_B_DNX;
			end
			S_B_DNX: begin
				cmd.mul_sel = MUL_DNX;
				state_d     = S_B_RX;
			end
			S_B_RX: begin
				cmd.act     = ACT_RX;
				cmd.mul_sel = MUL_DNY;
				state_d     = S_B_RY;
			end
			S_B_RY: begin
				cmd.act = ACT_RY;
				state_d = S_B_HALVE;
			end
			S_B_HALVE: begin
				if (sts.need_halve)
					cmd.act = ACT_HALVE;
				else
					state_d = S_B_BSQX;
			end
			S_B_BSQX: begin
				cmd.mul_sel = MUL_BXBX;
				state_d     = S_B_BSQY;
			end
			S_B_BSQY: begin
				cmd.mul_sel = MUL_BYBY;
				cmd.act     = ACT_ACC_LD;
				state_d     = S_B_BSUM;
			end
			S_B_BSUM: begin
				cmd.act = ACT_ACC_ADD;
				state_d = S_B_LSQLD;
			end
			S_B_LSQLD: begin
				cmd.act = ACT_SQRT_LD;
				state_d = S_B_LSQ;
			end
			S_B_LSQ: begin
				cmd.act = ACT_SQRT_STEP;
				if (sts.sqrt_last)
					state_d = S_B_LCHK;
			end
			S_B_LCHK: begin
				if (sts.len_zero) begin
					cmd.act = ACT_DEGEN;
					state_d = S_B_PNX;
				end else begin
					cmd.mul_sel = MUL_SBX;
					state_d     = S_B_DXLD;
				end
			end
			S_B_DXLD: begin
				cmd.act = ACT_DIV_LD;
				state_d = S_B_DX;
			end
			S_B_DX: begin
				cmd.act = ACT_DIV_STEP;
				if (sts.div_last)
					state_d = S_B_VX;
			end
			S_B_VX: begin
				cmd.act     = ACT_VX_SET;
				cmd.mul_sel = MUL_SBY;
				state_d     = S_B_DYLD;
			end
			S_B_DYLD: begin
				cmd.act = ACT_DIV_LD;
				state_d = S_B_DY;
			end
			S_B_DY: begin
				cmd.act = ACT_DIV_STEP;
				if (sts.div_last)
					state_d = S_B_VY;
			end
			S_B_VY: begin
				cmd.act = ACT_VY_SET;
				state_d = S_B_PNX;
			end
			S_B_PNX: begin
				cmd.mul_sel = MUL_PNX;
				state_d     = S_B_PUSHX;
			end
			S_B_PUSHX: begin
				cmd.act     = ACT_PUSH_X;
				cmd.mul_sel = MUL_PNY;
				state_d     = S_B_PUSHY;
			end
			S_B_PUSHY: begin
				cmd.act = ACT_PUSH_Y;
				state_d = S_DONE;
			end
			S_DONE: begin
				// output register must be free before it is reloaded
				if (!out_valid_q || out_ready) begin
					cmd.act = ACT_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.act == ACT_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/bbp_dpath.sv =====
// Datapath of the ball bounce physics step core: state, config registers,
// shared multiplier, bit-serial square root and divider, output register.
// Depends on bbp_pkg.
`default_nettype none

module bbp_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  bbp_pkg::bbp_cmd_t       cmd,
	output bbp_pkg::bbp_sts_t       sts,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [1:0]         op,
	input  wire logic [15:0]        delta_time,
	input  wire logic               colliding,
	input  wire logic               normal_valid,
	input  wire logic signed [15:0] normal_x,
	input  wire logic signed [15:0] normal_y,
	input  wire logic signed [31:0] penetration,
	input  wire logic [15:0]        speed_mul,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic                    degenerate
);
	import bbp_pkg::*;

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (x < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	// architectural state and config
	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [31:0] gravity_q;
	logic [30:0]        min_speed_q, max_speed_q;

	// captured item
	logic [1:0]         op_q;
	logic [15:0]        dt_q, smul_q;
	logic               coll_q, nval_q;
	logic signed [15:0] nx_q, ny_q;
	logic signed [31:0] pen_q;

	// working registers
	logic signed [68:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [34:0] d_q;
	logic [30:0]        s_q;
	logic [36:0]        bx_q, by_q;
	logic               rx_neg_q, ry_neg_q;
	logic [63:0]        sq_x_q;
	logic [33:0]        sq_rem_q;
	logic [31:0]        root_q;
	logic [5:0]         cnt_q;
	logic [63:0]        dv_num_q;
	logic [31:0]        dv_rem_q;
	logic               degen_q;

	// combinational terms
	logic signed [35:0] ma;
	logic signed [32:0] mb;
	logic signed [68:0] t10, grav_r, r16, r14;
	logic signed [63:0] dsum, dr;
	logic signed [39:0] r14x2, rv40, ra40;
	logic               rv_neg;
	logic [39:0]        spd;
	logic [35:0]        sq_r2, sq_trial;
	logic               sq_ge;
	logic [32:0]        dv_t;
	logic               dv_ge;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_sel)
			MUL_VXVX: begin
				ma = {{4{vel_x_q[31]}}, vel_x_q};
				mb = {vel_x_q[31], vel_x_q};
			end
			MUL_VYVY: begin
				ma = {{4{vel_y_q[31]}}, vel_y_q};
				mb = {vel_y_q[31], vel_y_q};
			end
			MUL_VXNX: begin
				ma = {{4{vel_x_q[31]}}, vel_x_q};
				mb = {{17{nx_q[15]}}, nx_q};
			end
			MUL_VYNY: begin
				ma = {{4{vel_y_q[31]}}, vel_y_q};
				mb = {{17{ny_q[15]}}, ny_q};
			end
			MUL_VXDT: begin
				ma = {{4{vel_x_q[31]}}, vel_x_q};
				mb = {17'd0, dt_q};
			end
			MUL_VYDT: begin
				ma = {{4{vel_y_q[31]}}, vel_y_q};
				mb = {17'd0, dt_q};
			end
			MUL_GDT: begin
				ma = {{4{gravity_q[31]}}, gravity_q};
				mb = {17'd0, dt_q};
			end
			MUL_MAG: begin
				ma = {4'd0, root_q};
				mb = {17'd0, smul_q};
			end
			MUL_DNX: begin
				ma = {d_q[34], d_q};
				mb = {{17{nx_q[15]}}, nx_q};
			end
			MUL_DNY: begin
				ma = {d_q[34], d_q};
				mb = {{17{ny_q[15]}}, ny_q};
			end
			MUL_BXBX: begin
				ma = {5'd0, bx_q[30:0]};
				mb = {2'd0, bx_q[30:0]};
			end
			MUL_BYBY: begin
				ma = {5'd0, by_q[30:0]};
				mb = {2'd0, by_q[30:0]};
			end
			MUL_SBX: begin
				ma = {5'd0, s_q};
				mb = {2'd0, bx_q[30:0]};
			end
			MUL_SBY: begin
				ma = {5'd0, s_q};
				mb = {2'd0, by_q[30:0]};
			end
			MUL_PNX: begin
				ma = {{4{pen_q[31]}}, pen_q};
				mb = {{17{nx_q[15]}}, nx_q};
			end
			MUL_PNY: begin
				ma = {{4{pen_q[31]}}, pen_q};
				mb = {{17{ny_q[15]}}, ny_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		t10    = (prod_q <<< 3) + (prod_q <<< 1);
		grav_r = (t10 + 69'sd32768) >>> 16;
		r16    = (prod_q + 69'sd32768) >>> 16;
		r14    = (prod_q + 69'sd8192) >>> 14;
		dsum   = acc_q + $signed(prod_q[63:0]);
		dr     = (dsum + 64'sd8192) >>> 14;
		r14x2  = $signed({r14[38:0], 1'b0});
		// reflected component: the x path and y path share this subtractor
		if (cmd.act == ACT_RY)
			rv40 = $signed({{8{vel_y_q[31]}}, vel_y_q}) - r14x2;
		else
			rv40 = $signed({{8{vel_x_q[31]}}, vel_x_q}) - r14x2;
		rv_neg   = rv40[39];
		ra40     = rv_neg ? -rv40 : rv40;
		spd      = prod_q[47:8];
		sq_r2    = {sq_rem_q, sq_x_q[63:62]};
		sq_trial = {2'd0, root_q, 2'b01};
		sq_ge    = (sq_r2 >= sq_trial);
		dv_t     = {dv_rem_q, dv_num_q[63]};
		dv_ge    = (dv_t >= {1'b0, root_q});
	end

	// state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= POS_X_RST;
			pos_y_q     <= POS_Y_RST;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			gravity_q   <= GRAVITY_RST;
			min_speed_q <= MIN_SPEED_RST;
			max_speed_q <= MAX_SPEED_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAVITY:   gravity_q   <= cfg_data;
					REG_MIN_SPEED: min_speed_q <= cfg_data[30:0];
					REG_MAX_SPEED: max_speed_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (cmd.act)
				ACT_VY_ADD:
					vel_y_q <= sat32($signed({{32{vel_y_q[31]}}, vel_y_q}) + acc_q);
				ACT_MOVE_X:
					pos_x_q <= sat32($signed({{32{pos_x_q[31]}}, pos_x_q})
						+ $signed(r16[63:0]));
				ACT_MOVE_Y:
					pos_y_q <= sat32($signed({{32{pos_y_q[31]}}, pos_y_q})
						+ $signed(r16[63:0]));
				ACT_DEGEN: begin
					vel_x_q <= '0;
					vel_y_q <= '0;
				end
				ACT_VX_SET:
					vel_x_q <= rx_neg_q ? (32'd0 - dv_num_q[31:0]) : dv_num_q[31:0];
				ACT_VY_SET:
					vel_y_q <= ry_neg_q ? (32'd0 - dv_num_q[31:0]) : dv_num_q[31:0];
				ACT_PUSH_X:
					pos_x_q <= sat32($signed({{32{pos_x_q[31]}}, pos_x_q})
						+ $signed(r14[63:0]));
				ACT_PUSH_Y:
					pos_y_q <= sat32($signed({{32{pos_y_q[31]}}, pos_y_q})
						+ $signed(r14[63:0]));
				default: ;
			endcase
		end
	end

	// item capture, working registers, output register
	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MUL_NONE)
			prod_q <= ma * mb;
		if (cmd.capture) begin
			op_q    <= op;
			dt_q    <= delta_time;
			coll_q  <= colliding;
			nval_q  <= normal_valid;
			nx_q    <= normal_x;
			ny_q    <= normal_y;
			pen_q   <= penetration;
			smul_q  <= speed_mul;
			degen_q <= 1'b0;
		end
		case (cmd.act)
			ACT_GRAV:    acc_q <= grav_r[63:0];
			ACT_ACC_LD:  acc_q <= prod_q[63:0];
			ACT_ACC_ADD: acc_q <= acc_q + $signed(prod_q[63:0]);
			ACT_DOT_LD:  acc_q <= prod_q[63:0];
			ACT_DOT_RND: d_q   <= dr[34:0];
			ACT_SQRT_LD: begin
				sq_x_q   <= acc_q;
				sq_rem_q <= '0;
				root_q   <= '0;
				cnt_q    <= '0;
			end
			ACT_SQRT_STEP: begin
				sq_x_q <= {sq_x_q[61:0], 2'b00};
				cnt_q  <= cnt_q + 6'd1;
				if (sq_ge) begin
					sq_rem_q <= 34'(sq_r2 - sq_trial);
					root_q   <= {root_q[30:0], 1'b1};
				end else begin
					sq_rem_q <= sq_r2[33:0];
					root_q   <= {root_q[30:0], 1'b0};
				end
			end
			ACT_SPEED: begin
				if (spd > {9'd0, max_speed_q})
					s_q <= max_speed_q;
				else if (spd < {9'd0, min_speed_q})
					s_q <= min_speed_q;
				else
					s_q <= spd[30:0];
			end
			ACT_RX: begin
				bx_q     <= ra40[36:0];
				rx_neg_q <= rv_neg;
			end
			ACT_RY: begin
				by_q     <= ra40[36:0];
				ry_neg_q <= rv_neg;
			end
			ACT_HALVE: begin
				bx_q <= bx_q >> 1;
				by_q <= by_q >> 1;
			end
			ACT_DEGEN: degen_q <= 1'b1;
			ACT_DIV_LD: begin
				dv_num_q <= prod_q[63:0];
				dv_rem_q <= '0;
				cnt_q    <= '0;
			end
			ACT_DIV_STEP: begin
				cnt_q    <= cnt_q + 6'd1;
				dv_num_q <= {dv_num_q[62:0], dv_ge};
				dv_rem_q <= dv_ge ? 32'(dv_t - {1'b0, root_q}) : dv_t[31:0];
			end
			ACT_OUT: begin
				pos_x      <= pos_x_q;
				pos_y      <= pos_y_q;
				vel_x      <= vel_x_q;
				vel_y      <= vel_y_q;
				degenerate <= degen_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.op         = op_q;
		sts.bounce_go  = coll_q & nval_q;
		sts.sqrt_last  = (cnt_q == 6'd31);
		sts.div_last   = (cnt_q == 6'd63);
		sts.need_halve = (|bx_q[36:31]) | (|by_q[36:31]);
		sts.len_zero   = (root_q == 32'd0);
	end

endmodule

`default_nettype wire

// ===== hdl/ball_bounce_physics_step_core.sv =====
// Top level of the ball bounce physics step core.
// Instantiates bbp_ctrl and bbp_dpath; depends on bbp_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction per operation
//    (gravity, move or bounce) with its operand fields.
//  - Output channel (out_valid/out_ready): one transaction per input, the
//    ball state after the step plus the degenerate flag.
//  - Config channel (cfg_valid/cfg_ready): always ready; index 0 gravity,
//    1 min_speed, 2 max_speed, other indexes ignored. Write only when idle.
//  - The bounce time is set by the two 32-step square roots and the two
//    64-step restoring divides, all one bit per cycle, and the single
//    shared 36x33 multiplier. One item is worked on at a time; the core
//    is ready for the next input in the cycle after the result is loaded.
//  - A new input is taken while a finished result waits in the output
//    register; if the receiver stalls, the next result waits in the
//    controller until the output register frees.
//  - Reset: position goes to the screen centre, velocity to zero, config
//    registers to their defaults, both channels empty.
`default_nettype none

module ball_bounce_physics_step_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [15:0]        delta_time,
	input  wire logic               colliding,
	input  wire logic               normal_valid,
	input  wire logic signed [15:0] normal_x,
	input  wire logic signed [15:0] normal_y,
	input  wire logic signed [31:0] penetration,
	input  wire logic [15:0]        speed_mul,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic                    degenerate,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import bbp_pkg::*;

	bbp_cmd_t cmd;
	bbp_sts_t sts;

	// registers are plain flops, so a config write is always accepted
	assign cfg_ready = 1'b1;

	bbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bbp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.delta_time   (delta_time),
		.colliding    (colliding),
		.normal_valid (normal_valid),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.penetration  (penetration),
		.speed_mul    (speed_mul),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.degenerate   (degenerate)
	);

	// an accepted transaction takes the block out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an input transaction");

	// a zero reflected direction leaves the ball at rest
	a_degen_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> vel_x == 32'sd0 && vel_y == 32'sd0)
		else $error("degenerate result with non-zero velocity");

	// a result only leaves the output register through a transaction
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without out_ready");

endmodule

`default_nettype wire

// ===== tb/sv/ball_bounce_physics_step_core_tb.sv =====
// Self-checking testbench for ball_bounce_physics_step_core: a ball-state
// scoreboard class predicts every step, plain tasks drive the input and config channels.
// Depends on bbp_pkg and the core RTL only.
`default_nettype none

module ball_bounce_physics_step_core_tb;
	import bbp_pkg::*;

	localparam int STALL_LIMIT = 5000;  // cycles with no transaction on any channel
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int TAIL_CYCLES = 300;   // settle time after the last result
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic [15:0]        dt;
		logic               coll;
		logic               nvalid;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [31:0] pen;
		logic [15:0]        mul;
	} step_t;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               degen;
	} ball_state_t;

	// Ball state predictor plus the queue of states still owed by the core.
	class ball_state_scoreboard;
		longint px, py, vx, vy, grav;
		longint unsigned min_spd, max_spd;
		ball_state_t expected_states[$];
		int mismatches, checked, reg_writes;
		int n_grav, n_move, n_bounce, n_applied, n_degen, n_unused;

		function new();
			px = longint'(SCREEN_W / 2) * 65536;
			py = longint'(SCREEN_H / 2) * 65536;
			vx = 0;
			vy = 0;
			grav = 642908;
			min_spd = 9830400;
			max_spd = 32768000;
		endfunction

		function automatic longint clamp32(longint x);
			if (x > 64'sd2147483647)
				return 64'sd2147483647;
			if (x < -64'sd2147483648)
				return -64'sd2147483648;
			return x;
		endfunction

		// round half up, then floor shift
		function automatic longint round_shift(longint x, int s);
			return (x + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function automatic longint unsigned int_sqrt(longint unsigned x);
			longint unsigned res = 0;
			longint unsigned b = 64'h4000_0000_0000_0000;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] data);
			reg_writes++;
			case (idx)
				REG_GRAVITY:   grav = longint'(signed'(data));
				REG_MIN_SPEED: min_spd = data[30:0];
				REG_MAX_SPEED: max_spd = data[30:0];
				default: ;
			endcase
		endfunction

		// reflect v about n, rescale to the clamped speed, push out along n
		function automatic bit reflect(longint nx, longint ny, longint pen,
				longint unsigned mul);
			longint unsigned ax, ay, mag, spd, bx, by, len, qx, qy;
			longint d, ux, uy, rx, ry;
			bit degen = 0;
			ax = (vx < 0) ? -vx : vx;
			ay = (vy < 0) ? -vy : vy;
			mag = int_sqrt(ax * ax + ay * ay);
			spd = (mag * mul) >> 8;
			if (spd > max_spd)
				spd = max_spd;
			else if (spd < min_spd)
				spd = min_spd;
			d = round_shift(vx * nx + vy * ny, 14);
			ux = round_shift(d * nx, 14);
			uy = round_shift(d * ny, 14);
			rx = vx - 2 * ux;
			ry = vy - 2 * uy;
			bx = (rx < 0) ? -rx : rx;
			by = (ry < 0) ? -ry : ry;
			while (bx >= 64'd2147483648 || by >= 64'd2147483648) begin
				bx >>= 1;
				by >>= 1;
			end
			len = int_sqrt(bx * bx + by * by);
			if (len == 0) begin
				vx = 0;
				vy = 0;
				degen = 1;
			end else begin
				qx = (spd * bx) / len;
				qy = (spd * by) / len;
				vx = (rx < 0) ? -longint'(qx) : longint'(qx);
				vy = (ry < 0) ? -longint'(qy) : longint'(qy);
			end
			px = clamp32(px + round_shift(pen * nx, 14));
			py = clamp32(py + round_shift(pen * ny, 14));
			return degen;
		endfunction

		function void note_step(step_t s);
			longint dt, nx, ny, pen;
			ball_state_t e;
			dt = longint'(s.dt);
			nx = longint'(s.nx);
			ny = longint'(s.ny);
			pen = longint'(s.pen);
			e.degen = 0;
			case (s.op)
				OP_GRAVITY: begin
					n_grav++;
					vy = clamp32(vy + round_shift(dt * grav * 10, 16));
				end
				OP_MOVE: begin
					n_move++;
					px = clamp32(px + round_shift(vx * dt, 16));
					py = clamp32(py + round_shift(vy * dt, 16));
				end
				OP_BOUNCE: begin
					n_bounce++;
					if (s.coll && s.nvalid) begin
						n_applied++;
						e.degen = reflect(nx, ny, pen, longint'(s.mul));
						n_degen += e.degen;
					end
				end
				default: n_unused++;
			endcase
			e.px = px[31:0];
			e.py = py[31:0];
			e.vx = vx[31:0];
			e.vy = vy[31:0];
			expected_states.push_back(e);
		endfunction

		function void report(string what, ball_state_t e, ball_state_t a);
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t mismatch %s: exp px=%0d py=%0d vx=%0d vy=%0d dg=%0b,",
					" got px=%0d py=%0d vx=%0d vy=%0d dg=%0b"},
					$time, what, e.px, e.py, e.vx, e.vy, e.degen,
					a.px, a.py, a.vx, a.vy, a.degen);
		endfunction

		function void check_state(ball_state_t a);
			ball_state_t e;
			checked++;
			if (expected_states.size() == 0) begin
				e = a;
				report("(no result pending)", e, a);
				return;
			end
			e = expected_states.pop_front();
			if (a.px !== e.px) report("pos_x", e, a);
			if (a.py !== e.py) report("pos_y", e, a);
			if (a.vx !== e.vx) report("vel_x", e, a);
			if (a.vy !== e.vy) report("vel_y", e, a);
			if (a.degen !== e.degen) report("degenerate", e, a);
		endfunction

		function int pending();
			return expected_states.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid, in_ready;
	logic [1:0]         op;
	logic [15:0]        delta_time;
	logic               colliding, normal_valid;
	logic signed [15:0] normal_x, normal_y;
	logic signed [31:0] penetration;
	logic [15:0]        speed_mul;
	logic               out_valid, out_ready;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
	logic               degenerate;
	logic               cfg_valid, cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	ball_state_scoreboard tracker = new();
	bit quiet;          // no idling on either side while set
	bit hold_req;       // asks the receiver for one long hold-off
	int stall_cycles;
	int n_settings;

	ball_bounce_physics_step_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .delta_time(delta_time), .colliding(colliding),
		.normal_valid(normal_valid), .normal_x(normal_x), .normal_y(normal_y),
		.penetration(penetration), .speed_mul(speed_mul),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.degenerate(degenerate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Result monitor and stall counter; outputs sampled on the rising edge.
	always @(posedge clk) begin
		ball_state_t got;
		if (arst_n && out_valid && out_ready) begin
			got.px = pos_x;
			got.py = pos_y;
			got.vx = vel_x;
			got.vy = vel_y;
			got.degen = degenerate;
			tracker.check_state(got);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	// Receiver: ~7% stalls, none while quiet, one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = quiet || ($urandom_range(99) >= 7);
		end
	end

	// Watchdog: ends the run if the channels go quiet for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
			STALL_LIMIT, tracker.pending());
		$display("TEST FAILED");
		$finish;
	end

	function automatic step_t make_step(logic [1:0] o, logic [15:0] dt, logic c,
			logic v, logic signed [15:0] nx, logic signed [15:0] ny,
			logic signed [31:0] pen, logic [15:0] mul);
		step_t s;
		s.op = o;
		s.dt = dt;
		s.coll = c;
		s.nvalid = v;
		s.nx = nx;
		s.ny = ny;
		s.pen = pen;
		s.mul = mul;
		return s;
	endfunction

	// Random step: a mix of gravity, move and bounce ops, bounces mostly applicable and on unit normals, with some noise.
	function automatic step_t rand_step();
		step_t s;
		int r;
		logic signed [15:0] ux[5] = '{16384, 0, 11585, 15137, 6270};
		logic signed [15:0] uy[5] = '{0, 16384, 11585, 6270, 15137};
		r = $urandom_range(99);
		s.op = (r < 28) ? OP_GRAVITY : (r < 56) ? OP_MOVE
			: (r < 95) ? OP_BOUNCE : OP_UNUSED;
		s.dt = ($urandom_range(9) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
		s.coll = ($urandom_range(9) != 0);
		s.nvalid = ($urandom_range(9) != 0);
		if ($urandom_range(9) < 7) begin
			r = $urandom_range(4);
			s.nx = $urandom_range(1) ? -ux[r] : ux[r];
			s.ny = $urandom_range(1) ? -uy[r] : uy[r];
		end else begin
			s.nx = 16'($urandom);
			s.ny = 16'($urandom);
		end
		if ($urandom_range(9) < 7)
			s.pen = 32'($urandom_range(2621440)) - 32'd1310720;
		else
			s.pen = $urandom;
		r = $urandom_range(99);
		s.mul = (r < 5) ? 16'd0 : (r < 85) ? 16'($urandom_range(128, 512))
			: 16'($urandom);
		return s;
	endfunction

	// Offer one step and hold it until accepted; entered and left at a falling edge.
	task automatic drive_step(input step_t s);
		if (!quiet && $urandom_range(99) < 7) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		op = s.op;
		delta_time = s.dt;
		colliding = s.coll;
		normal_valid = s.nvalid;
		normal_x = s.nx;
		normal_y = s.ny;
		penetration = s.pen;
		speed_mul = s.mul;
		do @(posedge clk); while (!in_ready);
		tracker.note_step(s);
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed result has been taken.
	task automatic drain();
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// New register setting, only with the core idle.
	task automatic configure(input logic [31:0] g, input logic [31:0] lo,
			input logic [31:0] hi);
		drain();
		repeat (8) @(negedge clk);
		write_reg(REG_GRAVITY, g);
		write_reg(REG_MIN_SPEED, lo);
		write_reg(REG_MAX_SPEED, hi);
		n_settings++;
	endtask

	task automatic run_random(input int count, input bit with_hold, input bit with_pause);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 40)
				hold_req = 1'b1;
			if (with_pause && i == 60)
				drain();
			drive_step(rand_step());
		end
	endtask

	initial begin
		step_t directed[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_GRAVITY;
		delta_time = '0;
		colliding = 1'b0;
		normal_valid = 1'b0;
		normal_x = '0;
		normal_y = '0;
		penetration = '0;
		speed_mul = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRAVITY;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		n_settings = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed steps at the reset settings.
		// ball at rest: unused op reports state, a bounce then finds a zero reflection
		directed.push_back(make_step(OP_UNUSED, 16'hFFFF, 1, 1, 16'sh7FFF, -16'sh8000,
			32'hFFFF_FFFF, 16'hFFFF));
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, 16'sd16384, 16'sd0,
			32'sd65536, 16'd256));
		directed.push_back(make_step(OP_GRAVITY, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_step(OP_GRAVITY, 16'd0, 1, 1, -1, -1, -1, 16'hFFFF));
		directed.push_back(make_step(OP_MOVE, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_step(OP_MOVE, 16'd1, 1, 1, 0, 0, 0, 0));
		// bounce suppressed: no collision, then a normal flagged not valid
		directed.push_back(make_step(OP_BOUNCE, 16'd100, 0, 1, 16'sd0, -16'sd16384,
			32'sd65536, 16'd256));
		directed.push_back(make_step(OP_BOUNCE, 16'd100, 1, 0, 16'sd0, -16'sd16384,
			32'sd65536, 16'd256));
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, 16'sd0, -16'sd16384,
			32'sd0, 16'd256));
		// non-unit normals used as given, extreme push-out and multipliers
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, -16'sh8000, 16'sh7FFF,
			32'sh7FFF_FFFF, 16'hFFFF));
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, 16'sh7FFF, -16'sh8000,
			-32'sh8000_0000, 16'd0));
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, 16'sd0, 16'sd0,
			32'sd0, 16'd512));
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, 16'sd11585, 16'sd11585,
			-32'sd65536, 16'd300));
		for (int i = 0; i < 4; i++)
			directed.push_back(make_step(OP_GRAVITY, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_step(OP_MOVE, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_step(OP_BOUNCE, 16'd0, 1, 1, 16'sd0, 16'sd16384,
			32'sd4096, 16'd256));
		directed.push_back(make_step(OP_UNUSED, 16'd0, 0, 0, 0, 0, 0, 0));
		foreach (directed[i])
			drive_step(directed[i]);

		// Extreme settings: strongest gravity both ways drives saturation,
		// and a minimum above the maximum tests the clamp order.
		configure(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			drive_step(make_step(OP_GRAVITY, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 3; i++)
			drive_step(make_step(OP_MOVE, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		run_random(180, 0, 0);

		configure(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
		for (int i = 0; i < 6; i++)
			drive_step(make_step(OP_GRAVITY, 16'hFFFF, 0, 0, 0, 0, 0, 0));
		run_random(180, 0, 0);

		// Back to the reset values; first part with no idling, then the long hold-off.
		configure(32'd642908, 32'd9830400, 32'd32768000);
		quiet = 1'b1;
		run_random(220, 0, 0);
		quiet = 1'b0;
		run_random(220, 1, 0);

		configure(32'hFFF6_2E6C, 32'd0, 32'd65536000);
		run_random(220, 0, 1);

		for (int k = 0; k < 2; k++) begin
			configure($urandom, $urandom, $urandom);
			run_random(200, 0, 0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.pending() != 0) begin
			$display("%0d expected results never arrived", tracker.pending());
			tracker.mismatches += tracker.pending();
		end
		$display({"Ran %0d steps: %0d gravity, %0d move, %0d bounce",
			" (%0d applied, %0d degenerate), %0d unused op"},
			tracker.n_grav + tracker.n_move + tracker.n_bounce + tracker.n_unused,
			tracker.n_grav, tracker.n_move, tracker.n_bounce, tracker.n_applied,
			tracker.n_degen, tracker.n_unused);
		$display("%0d register writes over %0d settings, %0d results checked, %0d mismatches",
			tracker.reg_writes, n_settings, tracker.checked, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
